FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checks that a condition never holds while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

FILE: hw/rtl/srs_pkg.sv
// Package of the slot record store: field layout, command codes and control structs.
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

	localparam int NAME_BYTES = 16;
	localparam int NAME_W     = 128;
	localparam int VAL_W      = 80;
	localparam int REC_W      = NAME_W + VAL_W;
	localparam int SLOT_W     = 6;
	localparam int CFG_W      = 16;

	// Input item layout.
	localparam int IN_W         = 240;
	localparam int IN_USER_W    = 3;
	localparam int IN_IDX_LSB   = 0;
	localparam int IN_NAME_LSB  = 8;
	localparam int IN_QLEN_LSB  = 136;
	localparam int IN_VAL_LSB   = 141;
	localparam int IN_CAP_LSB   = 221;
	localparam int IN_START_LSB = 229;

	// Result item layout.
	localparam int OUT_W      = 240;
	localparam int OUT_USER_W = 1;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_DEL   = 3'd1,
		CMD_LOAD  = 3'd2,
		CMD_GET   = 3'd3,
		CMD_COUNT = 3'd4,
		CMD_FILT  = 3'd5,
		CMD_ERASE = 3'd6
	} srs_op_t;

	// Which fields a result item carries.
	typedef enum logic [2:0] {
		K_PLAIN = 3'd0,
		K_FOUND = 3'd1,
		K_COUNT = 3'd2,
		K_ENTRY = 3'd3,
		K_MATCH = 3'd4,
		K_FINAL = 3'd5
	} srs_kind_t;

	typedef struct packed {
		logic      capture;
		logic      scan_inc;
		logic      cnt_inc;
		logic      wr_en;
		logic      del_en;
		logic      clr_all;
		logic      rd_idx;
		logic      rd_scan;
		logic      fadv;
		logic      out_load;
		srs_kind_t out_kind;
	} srs_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       occ_cur;
		logic       scan_last;
		logic       scan_over;
		logic       cnt_hit;
		logic       idx_ok;
		logic       cap_hit;
		logic       v_s1;
		logic       match_s1;
		logic       out_free;
	} srs_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/slot_record_store.sv
// Items take one at a time; the next item is accepted once the last result is loaded.
// Delete, erase, load: dispatch, then the response or read state loads the result.
// Add, count and get nth: one slot per cycle, then the result when the output is free.
// Filter: scans to the last slot or the match cap, held while a match waits on output.
// Reset clears occupancy flags (every slot empty), match_id_base and all control;
// the record array itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module slot_record_store #(
	parameter int SLOTS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// slot_index, name_lo, name_hi, query_len, kcal_in, protein_in, fat_in,
	// carbs_in, fiber_in, match_cap, start_count, zero fill
	input  wire logic [srs_pkg::IN_W-1:0]       s_axis_tdata,
	// cmd
	input  wire logic [srs_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// slot_out, name_lo_out, name_hi_out, kcal_out, protein_out, fat_out,
	// carbs_out, fiber_out, count_out, match_id, zero fill
	output logic [srs_pkg::OUT_W-1:0]           m_axis_tdata,
	// found
	output logic [srs_pkg::OUT_USER_W-1:0]      m_axis_tuser,
	output logic                                m_axis_tlast,
	input  wire logic                           cfg_wen,
	input  wire logic [srs_pkg::CFG_W-1:0]      cfg_wdata
);

	srs_pkg::srs_cmd_t    ctl;
	srs_pkg::srs_status_t status;

	srs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.ctl      (ctl),
		.status   (status)
	);

	srs_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.status    (status),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/srs_dp.sv
// Datapath of the slot record store: record array, occupancy flags, scan and count registers.
`timescale 1ns / 1ps
`default_nettype none

module srs_dp #(
	parameter int SLOTS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [srs_pkg::IN_W-1:0]     in_data,
	input  wire logic [srs_pkg::IN_USER_W-1:0] in_user,
	input  wire logic                         cfg_wen,
	input  wire logic [srs_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire srs_pkg::srs_cmd_t            ctl,
	output srs_pkg::srs_status_t              status,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [srs_pkg::OUT_W-1:0]         out_data,
	output logic [srs_pkg::OUT_USER_W-1:0]    out_user,
	output logic                              out_last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [2:0]                    op_q;
	logic [7:0]                    idx_q;
	logic [srs_pkg::NAME_W-1:0]    name_q;
	logic [srs_pkg::VAL_W-1:0]     vals_q;
	logic [4:0]                    qlen_q;
	logic [7:0]                    cap_q;
	logic [7:0]                    cnt_q;
	logic [srs_pkg::CFG_W-1:0]     base_q;
	logic [IW-1:0]                 scan_q;
	logic                          over_q;
	logic [SLOTS-1:0]              occ_q;
	logic [srs_pkg::REC_W-1:0]     mem [SLOTS];
	logic [srs_pkg::REC_W-1:0]     rd_q;
	logic [IW-1:0]                 slot_s1;
	logic                          occ_s1;
	logic                          v_s1;
	logic                          out_valid_q;
	logic                          found_q;
	logic [srs_pkg::SLOT_W-1:0]    slot_q;
	logic [srs_pkg::NAME_W-1:0]    oname_q;
	logic [srs_pkg::VAL_W-1:0]     ovals_q;
	logic [7:0]                    ocnt_q;
	logic [15:0]                   omid_q;
	logic                          olast_q;

	logic                          fstep;
	logic                          step;
	logic                          rd_en;
	logic [IW-1:0]                 rd_addr;
	logic                          idx_in;
	logic                          match;
	logic                          out_free;
	logic                          n_found;
	logic [srs_pkg::SLOT_W-1:0]    n_slot;
	logic [srs_pkg::NAME_W-1:0]    n_name;
	logic [srs_pkg::VAL_W-1:0]     n_vals;
	logic [7:0]                    n_cnt;
	logic [15:0]                   n_mid;
	logic                          n_last;

	// Keeps name bytes up to the first zero byte and clears the rest.
	function automatic logic [srs_pkg::NAME_W-1:0] pad_name(input logic [srs_pkg::NAME_W-1:0] nm);
		logic [srs_pkg::NAME_W-1:0] r;
		logic                       live;
		r    = '0;
		live = 1'b1;
		for (int j = 0; j < srs_pkg::NAME_BYTES; j++) begin
			live = live & (nm[j*8 +: 8] != 8'd0);
			if (live) begin
				r[j*8 +: 8] = nm[j*8 +: 8];
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;
	endfunction

	assign fstep   = ctl.fadv & ~over_q;
	assign step    = ctl.scan_inc | fstep;
	assign rd_en   = ctl.rd_idx | ctl.rd_scan | fstep;
	assign rd_addr = ctl.rd_idx ? idx_q[IW-1:0] : scan_q;
	assign idx_in  = idx_q < 8'(SLOTS);
	assign out_free = ~out_valid_q | out_ready;

	// An occupied slot matches when the query length is at most NAME_BYTES and every query
	// byte below the length equals the upper-cased stored byte, which is not the terminator.
	always_comb begin
		logic ok;
		ok = occ_s1 && (qlen_q <= 5'(srs_pkg::NAME_BYTES));
		for (int j = 0; j < srs_pkg::NAME_BYTES; j++) begin
			if (5'(j) < qlen_q) begin
				ok = ok && (rd_q[j*8 +: 8] != 8'd0) &&
					(upcase(rd_q[j*8 +: 8]) == name_q[j*8 +: 8]);
			end
		end
		match = ok;
	end

	always_comb begin
		status.op        = op_q;
		status.occ_cur   = occ_q[scan_q];
		status.scan_last = scan_q == IW'(SLOTS - 1);
		status.scan_over = over_q;
		status.cnt_hit   = cnt_q == idx_q;
		status.idx_ok    = idx_in && occ_q[idx_q[IW-1:0]];
		status.cap_hit   = cnt_q == cap_q;
		status.v_s1      = v_s1;
		status.match_s1  = match;
		status.out_free  = out_free;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			over_q      <= 1'b0;
			v_s1        <= 1'b0;
			occ_q       <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				base_q <= cfg_wdata;
			end
			if (ctl.capture) begin
				scan_q <= '0;
				over_q <= 1'b0;
				v_s1   <= 1'b0;
			end else begin
				if (step) begin
					if (scan_q == IW'(SLOTS - 1)) begin
						over_q <= 1'b1;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				if (ctl.fadv) begin
					v_s1 <= ~over_q;
				end
			end
			if (ctl.clr_all) begin
				occ_q <= '0;
			end else if (ctl.del_en && idx_in) begin
				occ_q[idx_q[IW-1:0]] <= 1'b0;
			end else if (ctl.wr_en) begin
				occ_q[scan_q] <= name_q[7:0] != 8'd0;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item registers and counters.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q   <= in_user;
			idx_q  <= in_data[srs_pkg::IN_IDX_LSB +: 8];
			name_q <= pad_name(in_data[srs_pkg::IN_NAME_LSB +: srs_pkg::NAME_W]);
			vals_q <= in_data[srs_pkg::IN_VAL_LSB +: srs_pkg::VAL_W];
			qlen_q <= in_data[srs_pkg::IN_QLEN_LSB +: 5];
			cap_q  <= in_data[srs_pkg::IN_CAP_LSB +: 8];
			cnt_q  <= (in_user == srs_pkg::CMD_FILT) ?
				in_data[srs_pkg::IN_START_LSB +: 8] : 8'd0;
		end else if (ctl.cnt_inc) begin
			cnt_q <= cnt_q + 8'd1;
		end
		if (rd_en) begin
			slot_s1 <= rd_addr;
			occ_s1  <= occ_q[rd_addr];
		end
	end

	// Record array: one write port for add, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[scan_q] <= {vals_q, name_q};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		n_found = 1'b0;
		n_slot  = '0;
		n_name  = '0;
		n_vals  = '0;
		n_cnt   = '0;
		n_mid   = '0;
		n_last  = 1'b1;
		unique case (ctl.out_kind)
			srs_pkg::K_PLAIN: begin
			end
			srs_pkg::K_FOUND: begin
				n_found = 1'b1;
				n_slot  = srs_pkg::SLOT_W'(scan_q);
			end
			srs_pkg::K_COUNT, srs_pkg::K_FINAL: begin
				n_cnt = cnt_q;
			end
			srs_pkg::K_ENTRY: begin
				n_found = 1'b1;
				n_slot  = srs_pkg::SLOT_W'(slot_s1);
				n_name  = rd_q[srs_pkg::NAME_W-1:0];
				n_vals  = rd_q[srs_pkg::REC_W-1:srs_pkg::NAME_W];
			end
			srs_pkg::K_MATCH: begin
				n_found = 1'b1;
				n_slot  = srs_pkg::SLOT_W'(slot_s1);
				n_cnt   = cnt_q + 8'd1;
				n_mid   = base_q + 16'(slot_s1);
				n_last  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			found_q <= n_found;
			slot_q  <= n_slot;
			oname_q <= n_name;
			ovals_q <= n_vals;
			ocnt_q  <= n_cnt;
			omid_q  <= n_mid;
			olast_q <= n_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {2'b00, omid_q, ocnt_q, ovals_q, oname_q, slot_q};
	assign out_user  = found_q;
	assign out_last  = olast_q;

endmodule

`default_nettype wire

FILE: hw/rtl/srs_ctrl.sv
// Controller of the slot record store: sequences each command over the datapath.
`timescale 1ns / 1ps
`default_nettype none

module srs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output srs_pkg::srs_cmd_t         ctl,
	input  wire srs_pkg::srs_status_t status
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DISP = 6'b000010,
		S_SCAN = 6'b000100,
		S_RD   = 6'b001000,
		S_FILT = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	srs_pkg::srs_kind_t  kind_q;
	srs_pkg::srs_kind_t  kind_d;

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		kind_d   = kind_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (status.op)
					srs_pkg::CMD_ADD, srs_pkg::CMD_GET, srs_pkg::CMD_COUNT: begin
						state_d = S_SCAN;
					end
					srs_pkg::CMD_DEL: begin
						ctl.del_en = 1'b1;
						kind_d     = srs_pkg::K_PLAIN;
						state_d    = S_RESP;
					end
					srs_pkg::CMD_LOAD: begin
						if (status.idx_ok) begin
							ctl.rd_idx = 1'b1;
							state_d    = S_RD;
						end else begin
							kind_d  = srs_pkg::K_PLAIN;
							state_d = S_RESP;
						end
					end
					srs_pkg::CMD_FILT: begin
						state_d = S_FILT;
					end
					srs_pkg::CMD_ERASE: begin
						ctl.clr_all = 1'b1;
						kind_d      = srs_pkg::K_PLAIN;
						state_d     = S_RESP;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				// One slot per cycle, in slot order.
				case (status.op)
					srs_pkg::CMD_ADD: begin
						if (!status.occ_cur) begin
							ctl.wr_en = 1'b1;
							kind_d    = srs_pkg::K_FOUND;
							state_d   = S_RESP;
						end else if (status.scan_last) begin
							kind_d  = srs_pkg::K_PLAIN;
							state_d = S_RESP;
						end else begin
							ctl.scan_inc = 1'b1;
						end
					end
					srs_pkg::CMD_GET: begin
						if (status.occ_cur && status.cnt_hit) begin
							ctl.rd_scan = 1'b1;
							state_d     = S_RD;
						end else begin
							ctl.cnt_inc = status.occ_cur;
							if (status.scan_last) begin
								kind_d  = srs_pkg::K_PLAIN;
								state_d = S_RESP;
							end else begin
								ctl.scan_inc = 1'b1;
							end
						end
					end
					default: begin
						ctl.cnt_inc = status.occ_cur;
						if (status.scan_last) begin
							kind_d  = srs_pkg::K_COUNT;
							state_d = S_RESP;
						end else begin
							ctl.scan_inc = 1'b1;
						end
					end
				endcase
			end
			S_RD: begin
				if (status.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_kind = srs_pkg::K_ENTRY;
					state_d      = S_IDLE;
				end
			end
			S_FILT: begin
				// Read of the next slot overlaps the compare of the previous one;
				// a match that cannot leave yet holds the whole pipe.
				priority if (status.cap_hit) begin
					kind_d  = srs_pkg::K_FINAL;
					state_d = S_RESP;
				end else if (status.v_s1 && status.match_s1) begin
					if (status.out_free) begin
						ctl.out_load = 1'b1;
						ctl.out_kind = srs_pkg::K_MATCH;
						ctl.cnt_inc  = 1'b1;
						ctl.fadv     = 1'b1;
					end
				end else if (!status.v_s1 && status.scan_over) begin
					kind_d  = srs_pkg::K_FINAL;
					state_d = S_RESP;
				end else begin
					ctl.fadv = 1'b1;
				end
			end
			S_RESP: begin
				if (status.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_kind = kind_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= srs_pkg::K_PLAIN;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/srs_check.sv
// Port-level checker of the slot record store and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srs_check (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [srs_pkg::OUT_W-1:0]       m_axis_tdata,
	input wire logic [srs_pkg::OUT_USER_W-1:0]  m_axis_tuser,
	input wire logic                            m_axis_tlast
);

	`ASSERT_PROP(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result item changed while stalled")

	// A new item is only taken once every result of the previous one is loaded.
	`ASSERT_NEVER(a_no_overlap, clk, arst_n, s_axis_tready && m_axis_tvalid && !m_axis_tlast, "input ready while a command is still producing results")

	`ASSERT_PROP(a_match_found, clk, arst_n, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0], "non-final result item without found")

	`ASSERT_PROP(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready stayed high after an item was accepted")

endmodule

bind slot_record_store srs_check u_srs_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/slot_record_store_tb.sv
// Self-checking testbench for the slot record store: table commands, prefix filter, match ids.
`timescale 1ns / 1ps

module slot_record_store_tb;
	import srs_pkg::*;

	localparam int          SLOTS       = 32;
	localparam logic [2:0]  OP_NONE     = 3'd7;
	localparam int          HOLD_CYCLES = 400;
	localparam int          SETTLE      = 60;
	localparam int          CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [2:0]       op;
		logic [7:0]       slot_index;
		logic [127:0]     name;
		logic [4:0]       query_len;
		logic [4:0][15:0] vals;
		logic [7:0]       match_cap;
		logic [7:0]       start_count;
	} srs_item_t;

	typedef struct packed {
		logic             found;
		logic [5:0]       slot;
		logic [63:0]      name_lo;
		logic [63:0]      name_hi;
		logic [4:0][15:0] vals;
		logic [7:0]       count;
		logic [15:0]      match_id;
		logic             last;
	} srs_result_t;

	class record_scoreboard;
		logic [127:0]     names [SLOTS];
		logic [4:0][15:0] values [SLOTS];
		logic [15:0]      id_base;
		srs_result_t      expected_q[$];
		int               errors;

		function new();
			clear_table();
			id_base = '0;
			errors  = 0;
		endfunction

		function void clear_table();
			for (int s = 0; s < SLOTS; s++) begin
				names[s]  = '0;
				values[s] = '0;
			end
		endfunction

		function void set_base(logic [15:0] b);
			id_base = b;
		endfunction

		function bit is_empty(int s);
			return names[s][7:0] == 8'h00;
		endfunction

		// Keeps the bytes before the first zero byte and clears the rest.
		function logic [127:0] cut_at_zero(logic [127:0] nm);
			logic [127:0] w;
			w = '0;
			for (int j = 0; j < 16; j++) begin
				if (nm[8*j +: 8] == 8'h00)
					break;
				w[8*j +: 8] = nm[8*j +: 8];
			end
			return w;
		endfunction

		function srs_result_t entry_of(int s);
			srs_result_t r;
			logic [127:0] w;
			r       = '0;
			w       = cut_at_zero(names[s]);
			r.found = 1'b1;
			r.slot  = s[5:0];
			r.name_lo = w[63:0];
			r.name_hi = w[127:64];
			r.vals  = values[s];
			r.last  = 1'b1;
			return r;
		endfunction

		function bit prefix_hit(int s, logic [127:0] q, int qlen);
			logic [7:0] nc;
			if (qlen > 16)
				return 1'b0;
			for (int j = 0; j < qlen; j++) begin
				nc = names[s][8*j +: 8];
				if (nc == 8'h00)
					return 1'b0;
				if (nc >= 8'h61 && nc <= 8'h7A)
					nc = nc - 8'd32;
				if (nc != q[8*j +: 8])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_item(srs_item_t it);
			srs_result_t r;
			srs_result_t m;
			logic [7:0]  cnt;
			int          seen;
			r      = '0;
			r.last = 1'b1;
			case (it.op)
				CMD_ADD: begin
					for (int s = 0; s < SLOTS; s++) begin
						if (is_empty(s)) begin
							names[s]  = cut_at_zero(it.name);
							values[s] = it.vals;
							r.found   = 1'b1;
							r.slot    = s[5:0];
							break;
						end
					end
				end
				CMD_DEL: begin
					if (it.slot_index < SLOTS)
						names[it.slot_index][7:0] = 8'h00;
				end
				CMD_LOAD: begin
					if (it.slot_index < SLOTS && !is_empty(it.slot_index))
						r = entry_of(it.slot_index);
				end
				CMD_GET: begin
					seen = 0;
					for (int s = 0; s < SLOTS; s++) begin
						if (is_empty(s))
							continue;
						if (seen == it.slot_index) begin
							r = entry_of(s);
							break;
						end
						seen++;
					end
				end
				CMD_COUNT: begin
					cnt = '0;
					for (int s = 0; s < SLOTS; s++)
						if (!is_empty(s))
							cnt++;
					r.count = cnt;
				end
				CMD_FILT: begin
					cnt = it.start_count;
					for (int s = 0; s < SLOTS && cnt != it.match_cap; s++) begin
						if (is_empty(s) || !prefix_hit(s, it.name, it.query_len))
							continue;
						cnt        = cnt + 8'd1;
						m          = '0;
						m.found    = 1'b1;
						m.slot     = s[5:0];
						m.count    = cnt;
						m.match_id = id_base + 16'(s);
						expected_q.push_back(m);
					end
					r.count = cnt;
				end
				CMD_ERASE: clear_table();
				default: return;
			endcase
			expected_q.push_back(r);
		endfunction

		function void compare(string field, logic [63:0] e, logic [63:0] a);
			if (a !== e) begin
				$display("%0t ns: %s mismatch, expected %h actual %h", $time, field, e, a);
				errors++;
			end
		endfunction

		function void check_result(srs_result_t got);
			srs_result_t e;
			string       labels[5];
			labels = '{"kcal", "protein", "fat", "carbs", "fiber"};
			if (expected_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none actual %h", $time, got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare("found", e.found, got.found);
			compare("slot", e.slot, got.slot);
			compare("name_lo", e.name_lo, got.name_lo);
			compare("name_hi", e.name_hi, got.name_hi);
			for (int k = 0; k < 5; k++)
				compare(labels[k], e.vals[k], got.vals[k]);
			compare("count", e.count, got.count);
			compare("match_id", e.match_id, got.match_id);
			compare("last", e.last, got.last);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_wen;
	logic [CFG_W-1:0]      cfg_wdata;

	record_scoreboard sb;
	bit               hold_req;
	int               burst_left;
	int               cycles;

	slot_record_store #(.SLOTS(SLOTS)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		srs_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.found    = m_axis_tuser[0];
			got.slot     = m_axis_tdata[5:0];
			got.name_lo  = m_axis_tdata[69:6];
			got.name_hi  = m_axis_tdata[133:70];
			got.vals     = m_axis_tdata[213:134];
			got.count    = m_axis_tdata[221:214];
			got.match_id = m_axis_tdata[237:222];
			got.last     = m_axis_tlast;
			sb.check_result(got);
		end
	end

	// Receiver pacing: switches between always, random and mostly stalled ready, and once holds off
	// long enough for the block to back up.
	initial begin : rx_pace
		int mode;
		int mode_left;
		mode          = 0;
		mode_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req      = 1'b0;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 64);
			end
			mode_left--;
			case (mode)
				0: m_axis_tready = 1'b1;
				1: m_axis_tready = 1'($urandom_range(0, 1));
				default: m_axis_tready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic logic [127:0] name_of(string txt);
		logic [127:0] w;
		w = '0;
		for (int j = 0; j < txt.len() && j < 16; j++)
			w[8*j +: 8] = txt[j];
		return w;
	endfunction

	function automatic srs_item_t mk_item(logic [2:0] op, logic [7:0] idx, logic [127:0] nm,
			logic [4:0] qlen, logic [7:0] cap, logic [7:0] start, logic [15:0] v);
		srs_item_t it;
		it.op          = op;
		it.slot_index  = idx;
		it.name        = nm;
		it.query_len   = qlen;
		it.vals        = {v ^ 16'h0F0F, v + 16'd3, v ^ 16'hA5A5, ~v, v};
		it.match_cap   = cap;
		it.start_count = start;
		return it;
	endfunction

	function automatic logic [127:0] rand_name();
		logic [127:0] w;
		int           len;
		int           pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return {$urandom, $urandom, $urandom, $urandom};
		w   = '0;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
		for (int j = 0; j < len; j++)
			w[8*j +: 8] = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 3));
		// Now and then a zero byte in the middle, which cuts the stored name short.
		if (pick == 1)
			w[8*$urandom_range(0, 15) +: 8] = 8'h00;
		return w;
	endfunction

	function automatic srs_item_t rand_item(int add_pct, int filt_pct);
		srs_item_t it;
		int        r;
		int        qsel;
		it.slot_index  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 40))
				: 8'($urandom_range(0, 255));
		it.name        = rand_name();
		it.query_len   = 5'($urandom_range(0, 31));
		it.vals        = 80'({$urandom, $urandom, $urandom});
		it.match_cap   = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF;
		it.start_count = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
		r = $urandom_range(0, 99);
		if (r < add_pct) begin
			it.op = CMD_ADD;
		end else if (r < add_pct + filt_pct) begin
			it.op = CMD_FILT;
			qsel  = $urandom_range(0, 9);
			if (qsel < 7) begin
				// Short upper-case prefixes over the same few letters as the names.
				it.query_len = 5'($urandom_range(0, 3));
				it.name      = '0;
				for (int j = 0; j < it.query_len; j++)
					it.name[8*j +: 8] = 8'h41 + 8'($urandom_range(0, 3));
			end else if (qsel < 9) begin
				it.query_len = 5'($urandom_range(0, 16));
			end
		end else begin
			r = $urandom_range(0, 99);
			if (r < 25)
				it.op = CMD_DEL;
			else if (r < 50)
				it.op = CMD_LOAD;
			else if (r < 75)
				it.op = CMD_GET;
			else if (r < 92)
				it.op = CMD_COUNT;
			else if (r < 96)
				it.op = CMD_ERASE;
			else
				it.op = OP_NONE;
		end
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance, or after an idle gap.
	task automatic send_item(input srs_item_t it);
		s_axis_tdata  = {3'b000, it.start_count, it.match_cap, it.vals, it.query_len,
				it.name, it.slot_index};
		s_axis_tuser  = it.op;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(it);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_base(input logic [15:0] b);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_wdata = b;
		@(negedge clk);
		cfg_wen   = 1'b0;
		sb.set_base(b);
	endtask

	task automatic run_random(int n, int add_pct, int filt_pct);
		for (int i = 0; i < n; i++)
			send_item(rand_item(add_pct, filt_pct));
	endtask

	initial begin
		logic [127:0] ones;
		sb            = new();
		hold_req      = 1'b0;
		cycles        = 0;
		burst_left    = $urandom_range(0, 12);
		ones          = '1;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, with the id base at its top so match ids wrap.
		write_base(16'hFFFF);
		send_item(mk_item(CMD_COUNT, 8'd0, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_LOAD, 8'd0, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_GET, 8'd0, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_FILT, 8'd0, '0, 5'd0, 8'd255, 8'd7, 16'h0000));
		send_item(mk_item(CMD_ADD, 8'd0, name_of("apple"), 5'd0, 8'd0, 8'd0, 16'hFFFF));
		send_item(mk_item(CMD_ADD, 8'd0, ones, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_ADD, 8'd0, name_of("AB") | (name_of("CD") << 24), 5'd0,
				8'd0, 8'd0, 16'h1234));
		// Empty first byte: the slot is taken but stays empty.
		send_item(mk_item(CMD_ADD, 8'd0, ones << 8, 5'd0, 8'd0, 8'd0, 16'h8000));
		send_item(mk_item(CMD_ADD, 8'd0, name_of("Apricot"), 5'd0, 8'd0, 8'd0, 16'h7FFF));
		send_item(mk_item(CMD_LOAD, 8'd1, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_LOAD, 8'd255, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_LOAD, 8'd31, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_FILT, 8'd0, name_of("AP"), 5'd2, 8'd255, 8'd0, 16'h0000));
		send_item(mk_item(CMD_FILT, 8'd0, ones, 5'd16, 8'd255, 8'd0, 16'h0000));
		send_item(mk_item(CMD_FILT, 8'd0, '0, 5'd17, 8'd255, 8'd3, 16'h0000));
		send_item(mk_item(CMD_FILT, 8'd0, name_of("A"), 5'd2, 8'd255, 8'd0, 16'h0000));
		send_item(mk_item(CMD_FILT, 8'd0, '0, 5'd0, 8'd2, 8'd250, 16'h0000));
		send_item(mk_item(CMD_FILT, 8'd0, '0, 5'd0, 8'd5, 8'd5, 16'h0000));
		send_item(mk_item(CMD_FILT, 8'd0, '0, 5'd0, 8'd1, 8'd0, 16'h0000));
		send_item(mk_item(CMD_DEL, 8'd0, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_DEL, 8'd200, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_DEL, 8'd31, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_GET, 8'd0, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_GET, 8'd255, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(OP_NONE, 8'd0, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_ERASE, 8'd0, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		send_item(mk_item(CMD_COUNT, 8'd0, '0, 5'd0, 8'd0, 8'd0, 16'h0000));
		settle();

		// Mostly adds, so the table runs full.
		write_base(16'h0000);
		run_random(40, 85, 5);
		settle();

		write_base(16'($urandom));
		hold_req = 1'b1;
		run_random(20, 30, 30);
		settle();

		write_base(16'hFFE5);
		run_random(20, 25, 50);
		settle();

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
